### sv/cmacc_pkg.sv
`default_nettype none
package cmacc_pkg;

	localparam logic [1:0] REG_CLASS_COUNT = 2'd0;
	localparam logic [1:0] REG_POPULATION  = 2'd1;

	localparam logic [1:0] FN_RECORD = 2'd0;
	localparam logic [1:0] FN_CELL   = 2'd1;
	localparam logic [1:0] FN_METRIC = 2'd2;

	localparam int          FRAC_BITS = 15;
	localparam logic [15:0] Q15_FULL  = 16'd32768;
	localparam logic [15:0] DEC_FULL  = 16'd10000;

	localparam logic [6:0] CLASS_COUNT_RST = 7'd64;

	// divider request: start pulse, decimal (x10000) scaling instead of Q1.15
	typedef struct packed {
		logic start;
		logic dec;
	} div_ctrl_t;

endpackage
`default_nettype wire

### sv/cmacc_ram.sv
`default_nettype none
module cmacc_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### sv/cmacc_div.sv
`default_nettype none
module cmacc_div
	import cmacc_pkg::*;
#(
	parameter int DW = 34
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire div_ctrl_t     ctrl,
	input  wire logic [DW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic      [15:0]   quot
);

	localparam int PW = DW + FRAC_BITS;

	logic                 run_q;
	logic [3:0]           cnt_q;
	logic [DW-1:0]        r_q;
	logic [DW-1:0]        den_q;
	logic [FRAC_BITS-1:0] lo_q;
	logic [FRAC_BITS-1:0] q_q;
	logic                 done_q;
	logic [15:0]          quot_q;

	logic [PW-1:0]        prod;
	logic [DW:0]          trial;
	logic                 ge;
	logic [DW:0]          diff;

	// num * 10000 as shifted adds
	always_comb begin
		prod = (PW'(num) << 13) + (PW'(num) << 10) + (PW'(num) << 9)
			+ (PW'(num) << 8) + (PW'(num) << 4);
		trial = {r_q, lo_q[FRAC_BITS-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				cnt_q <= '0;
				if (den == '0) begin
					done_q <= 1'b1;
				end else if (num >= den) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(FRAC_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			den_q  <= den;
			q_q    <= '0;
			if (den == '0) begin
				quot_q <= '0;
			end else if (num >= den) begin
				quot_q <= ctrl.dec ? DEC_FULL : Q15_FULL;
			end
			if (ctrl.dec) begin
				r_q  <= prod[PW-1:FRAC_BITS];
				lo_q <= prod[FRAC_BITS-1:0];
			end else begin
				r_q  <= num;
				lo_q <= '0;
			end
		end else if (run_q) begin
			r_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			lo_q <= {lo_q[FRAC_BITS-2:0], 1'b0};
			q_q  <= {q_q[FRAC_BITS-2:0], ge};
			if (cnt_q == 4'(FRAC_BITS - 1)) begin
				quot_q <= {1'b0, q_q[FRAC_BITS-2:0], ge};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	a_no_start_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> !ctrl.start) else $error("divider restarted while busy");
	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q) else $error("divider done while still running");
	a_run_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> cnt_q < 4'(FRAC_BITS)) else $error("divider step count overrun");

endmodule
`default_nettype wire

### sv/classifier_metrics_accumulator_top.sv
`default_nettype none
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready   | func, actual_class, predicted_class, metric_class
// out     | output    | out_valid/out_ready | status, cell_count, counts, ratios, accuracy
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One request at a time. Record and cell read: the request passes S_RD (memory read, and
// update for a record) and S_OUT (output register load, held while a result still waits).
// Rejected request: straight to S_OUT. Metric read: five passes of the shared 15-step
// divider (no steps for a zero denominator or a full ratio). After reset a clearing pass
// over all MAX_CLASSES*MAX_CLASSES addresses zeroes the memories; no request is taken then.
// A result waiting in the output register does not block the next accept.
module classifier_metrics_accumulator_top
	import cmacc_pkg::*;
#(
	parameter int MAX_CLASSES = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [5:0]  actual_class,
	input  wire logic [5:0]  predicted_class,
	input  wire logic [5:0]  metric_class,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             status,
	output logic [31:0]      cell_count,
	output logic [31:0]      true_pos,
	output logic [31:0]      true_neg,
	output logic [31:0]      false_pos,
	output logic [31:0]      false_neg,
	output logic [15:0]      precision_q15,
	output logic [15:0]      recall_q15,
	output logic [15:0]      fscore_q15,
	output logic [13:0]      accuracy_hundredths,
	output logic [15:0]      overall_q15
);

	localparam int CW    = COUNT_WIDTH;
	localparam int IW    = $clog2(MAX_CLASSES);
	localparam int DEPTH = MAX_CLASSES * MAX_CLASSES;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = (CW + 2 > 32) ? CW + 2 : 32;

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_RD   = 6'b000100,
		S_DIV  = 6'b001000,
		S_WAIT = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;

	logic [6:0]    class_count_q;
	logic [31:0]   population_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] samples_q;
	logic [CW-1:0] correct_q;

	logic [1:0]    func_q;
	logic          err_q;
	logic [IW-1:0] a_q;
	logic [IW-1:0] p_q;
	logic [AW-1:0] caddr_q;
	logic [2:0]    k_q;

	logic [CW-1:0] cell_q, tp_q, fp_q, fn_q, tn_q;
	logic [15:0]   prec_q, rec_q, fsc_q, ovr_q;
	logic [13:0]   acc_q;

	logic          ovalid_q;
	logic          out_load;

	logic          accept, clearing, rec_wr, same;
	logic          ok_a, ok_p, ok_m, bad;
	logic [IW-1:0] a_idx, p_idx, m_idx;

	logic [AW-1:0] conf_raddr, conf_waddr;
	logic [IW-1:0] tp_raddr, fp_raddr, fn_raddr;
	logic [IW-1:0] tp_waddr, fp_waddr, fn_waddr;
	logic [CW-1:0] conf_rd, tp_rd, fp_rd, fn_rd;
	logic [CW-1:0] conf_wd, tp_wd, fp_wd, fn_wd;
	logic          conf_we, tp_we, fp_we, fn_we;

	logic [CW+1:0] used;
	div_ctrl_t     dctrl;
	logic [DW-1:0] dnum, dden;
	logic          ddone;
	logic [15:0]   dquot;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	assign clearing = state_q == S_CLR;
	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == S_OUT) && (!ovalid_q || out_ready);

	always_comb begin
		a_idx = IW'(actual_class);
		p_idx = IW'(predicted_class);
		m_idx = IW'(metric_class);
		ok_a  = ({1'b0, actual_class} < class_count_q) && (32'(actual_class) < MAX_CLASSES);
		ok_p  = ({1'b0, predicted_class} < class_count_q)
			&& (32'(predicted_class) < MAX_CLASSES);
		ok_m  = ({1'b0, metric_class} < class_count_q) && (32'(metric_class) < MAX_CLASSES);
		case (func)
			FN_RECORD, FN_CELL: bad = !(ok_a && ok_p);
			FN_METRIC:          bad = !ok_m;
			default:            bad = 1'b1;
		endcase
		conf_raddr = AW'(a_idx * MAX_CLASSES + p_idx);
		tp_raddr   = (func == FN_METRIC) ? m_idx : a_idx;
		fp_raddr   = (func == FN_METRIC) ? m_idx : p_idx;
		fn_raddr   = (func == FN_METRIC) ? m_idx : a_idx;
	end

	assign same   = a_q == p_q;
	assign rec_wr = (state_q == S_RD) && (func_q == FN_RECORD);

	always_comb begin
		conf_we    = clearing || rec_wr;
		conf_waddr = clearing ? clr_q : caddr_q;
		conf_wd    = clearing ? '0 : sat_inc(conf_rd);
		tp_we      = clearing || (rec_wr && same);
		tp_waddr   = clearing ? clr_q[IW-1:0] : a_q;
		tp_wd      = clearing ? '0 : sat_inc(tp_rd);
		fp_we      = clearing || (rec_wr && !same);
		fp_waddr   = clearing ? clr_q[IW-1:0] : p_q;
		fp_wd      = clearing ? '0 : sat_inc(fp_rd);
		fn_we      = clearing || (rec_wr && !same);
		fn_waddr   = clearing ? clr_q[IW-1:0] : a_q;
		fn_wd      = clearing ? '0 : sat_inc(fn_rd);
		used       = (CW+2)'(tp_rd) + (CW+2)'(fp_rd) + (CW+2)'(fn_rd);
	end

	cmacc_ram #(.DEPTH(DEPTH), .WIDTH(CW)) u_conf (
		.clk(clk), .we(conf_we), .waddr(conf_waddr), .wdata(conf_wd),
		.raddr(conf_raddr), .rdata(conf_rd)
	);
	cmacc_ram #(.DEPTH(MAX_CLASSES), .WIDTH(CW)) u_tp (
		.clk(clk), .we(tp_we), .waddr(tp_waddr), .wdata(tp_wd),
		.raddr(tp_raddr), .rdata(tp_rd)
	);
	cmacc_ram #(.DEPTH(MAX_CLASSES), .WIDTH(CW)) u_fp (
		.clk(clk), .we(fp_we), .waddr(fp_waddr), .wdata(fp_wd),
		.raddr(fp_raddr), .rdata(fp_rd)
	);
	cmacc_ram #(.DEPTH(MAX_CLASSES), .WIDTH(CW)) u_fn (
		.clk(clk), .we(fn_we), .waddr(fn_waddr), .wdata(fn_wd),
		.raddr(fn_raddr), .rdata(fn_rd)
	);

	// divider operands per pass: precision, recall, F-score, accuracy, overall
	always_comb begin
		dctrl.start = state_q == S_DIV;
		dctrl.dec   = k_q == 3'd3;
		case (k_q)
			3'd0: begin
				dnum = DW'(tp_q);
				dden = DW'(tp_q) + DW'(fp_q);
			end
			3'd1: begin
				dnum = DW'(tp_q);
				dden = DW'(tp_q) + DW'(fn_q);
			end
			3'd2: begin
				dnum = DW'(tp_q) << 1;
				dden = (DW'(tp_q) << 1) + DW'(fp_q) + DW'(fn_q);
			end
			3'd3: begin
				dnum = DW'(tp_q) + DW'(tn_q);
				dden = DW'(samples_q);
			end
			default: begin
				dnum = DW'(correct_q);
				dden = DW'(population_q);
			end
		endcase
	end

	cmacc_div #(.DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .ctrl(dctrl), .num(dnum), .den(dden),
		.done(ddone), .quot(dquot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			clr_q         <= '0;
			class_count_q <= CLASS_COUNT_RST;
			population_q  <= '0;
			samples_q     <= '0;
			correct_q     <= '0;
			ovalid_q      <= 1'b0;
			k_q           <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CLASS_COUNT: class_count_q <= cfg_data[6:0];
					REG_POPULATION:  population_q  <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= bad ? S_OUT : S_RD;
					end
				end
				S_RD: begin
					if (func_q == FN_RECORD) begin
						samples_q <= sat_inc(samples_q);
						if (same) begin
							correct_q <= sat_inc(correct_q);
						end
						state_q <= S_OUT;
					end else if (func_q == FN_CELL) begin
						state_q <= S_OUT;
					end else begin
						k_q     <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: state_q <= S_WAIT;
				S_WAIT: begin
					if (ddone) begin
						if (k_q == 3'd4) begin
							state_q <= S_OUT;
						end else begin
							k_q     <= k_q + 3'd1;
							state_q <= S_DIV;
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			err_q   <= bad;
			a_q     <= a_idx;
			p_q     <= p_idx;
			caddr_q <= conf_raddr;
		end
		if (state_q == S_RD) begin
			cell_q <= conf_rd;
			tp_q   <= tp_rd;
			fp_q   <= fp_rd;
			fn_q   <= fn_rd;
			tn_q   <= ((CW+2)'(samples_q) > used) ? CW'((CW+2)'(samples_q) - used) : '0;
		end
		if (state_q == S_WAIT && ddone) begin
			case (k_q)
				3'd0:    prec_q <= dquot;
				3'd1:    rec_q  <= dquot;
				3'd2:    fsc_q  <= dquot;
				3'd3:    acc_q  <= dquot[13:0];
				default: ovr_q  <= dquot;
			endcase
		end
		if (out_load) begin
			status              <= err_q;
			cell_count          <= (!err_q && func_q == FN_CELL) ? 32'(cell_q) : '0;
			true_pos            <= (!err_q && func_q == FN_METRIC) ? 32'(tp_q) : '0;
			true_neg            <= (!err_q && func_q == FN_METRIC) ? 32'(tn_q) : '0;
			false_pos           <= (!err_q && func_q == FN_METRIC) ? 32'(fp_q) : '0;
			false_neg           <= (!err_q && func_q == FN_METRIC) ? 32'(fn_q) : '0;
			precision_q15       <= (!err_q && func_q == FN_METRIC) ? prec_q : '0;
			recall_q15          <= (!err_q && func_q == FN_METRIC) ? rec_q : '0;
			fscore_q15          <= (!err_q && func_q == FN_METRIC) ? fsc_q : '0;
			accuracy_hundredths <= (!err_q && func_q == FN_METRIC) ? acc_q : '0;
			overall_q15         <= (!err_q && func_q == FN_METRIC) ? ovr_q : '0;
		end
	end

	assign out_valid = ovalid_q;

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_RD || state_q == S_OUT)) else $error("bad state after accept");
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ddone |-> state_q == S_WAIT) else $error("divider result outside wait");
	a_write_only_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(conf_we && !clearing) |-> (state_q == S_RD && !err_q))
		else $error("counter write outside update");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !in_ready) else $error("request taken during clear");

endmodule
`default_nettype wire
